[rtl/marker_length_xor_frame_deframer_assert.svh]
// Assertion macros used by the deframer top module.
`ifndef MARKER_LENGTH_XOR_FRAME_DEFRAMER_ASSERT_SVH
`define MARKER_LENGTH_XOR_FRAME_DEFRAMER_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define MLXD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MLXD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/mlxd_pkg.sv]
package mlxd_pkg;

  localparam int unsigned CountWidthDefault = 16;

  localparam logic [7:0] StartByte = 8'hA5;
  localparam logic [7:0] EndByte   = 8'h5A;
  localparam logic [7:0] Overhead  = 8'd4;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CHECK   = 5'b01000,
    PH_END     = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CHECKSUM = 2'd1,
    ERR_END      = 2'd2,
    ERR_SHORT    = 2'd3
  } err_e;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_good;
    logic        frame_error;
    err_e        error_kind;
    logic [7:0]  frame_payload_length;
    logic [15:0] good_frame_count;
    logic [15:0] bad_frame_count;
  } result_t;

endpackage

[rtl/marker_length_xor_frame_deframer.sv]
// Byte-stream deframer for frames of start byte 0xA5, total length L, L-4
// payload bytes, XOR checksum and end byte 0x5A.
// Input channel: in_valid_i / in_ready_o with data_byte_i, one byte per transfer.
// Output channel: out_valid_o / out_ready_i, exactly one result per input byte,
// carrying payload byte and index, frame good or error with its kind, the
// payload length of a good frame and the good and bad frame counters.
// Latency: a result is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result register is not stalled; the
// frame state updates once per accepted byte and the result is held in one output register.
// Stalls: while a result waits and out_ready_i is low, in_ready_o is low; when
// the result is taken, a new byte is accepted in the same cycle.
// Reset: rst_ni clears the frame state to start-byte hunting, zeroes both
// counters and empties the output register.
// Counters are COUNT_WIDTH bits wide and wrap; the ports show their low 16 bits.
module marker_length_xor_frame_deframer #(
  parameter int unsigned COUNT_WIDTH = mlxd_pkg::CountWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic        frame_good_o,
  output logic        frame_error_o,
  output logic [1:0]  error_kind_o,
  output logic [7:0]  frame_payload_length_o,
  output logic [15:0] good_frame_count_o,
  output logic [15:0] bad_frame_count_o
);

  `include "marker_length_xor_frame_deframer_assert.svh"

  logic              accept;
  logic              out_valid_q;
  mlxd_pkg::result_t result;
  mlxd_pkg::result_t result_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  mlxd_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign payload_valid_o        = result_q.payload_valid;
  assign payload_byte_o         = result_q.payload_byte;
  assign payload_index_o        = result_q.payload_index;
  assign frame_good_o           = result_q.frame_good;
  assign frame_error_o          = result_q.frame_error;
  assign error_kind_o           = result_q.error_kind;
  assign frame_payload_length_o = result_q.frame_payload_length;
  assign good_frame_count_o     = result_q.good_frame_count;
  assign bad_frame_count_o      = result_q.bad_frame_count;

  `MLXD_ASSERT(a_good_err_excl, out_valid_o |-> !(frame_good_o && frame_error_o),
               "frame good and frame error in the same result")
  `MLXD_ASSERT(a_kind_matches_err,
               out_valid_o |-> ((error_kind_o != mlxd_pkg::ERR_NONE) == frame_error_o),
               "error kind disagrees with frame error")
  `MLXD_ASSERT(a_payload_not_closing,
               out_valid_o |-> !(payload_valid_o && (frame_good_o || frame_error_o)),
               "payload byte also closes a frame")
  `MLXD_ASSERT_ALWAYS(a_no_accept_on_stall,
                      (out_valid_o && !out_ready_i) |-> !in_ready_o,
                      "input transfer while the result register is stalled")

endmodule

[rtl/mlxd_core.sv]
module mlxd_core #(
  parameter int unsigned COUNT_WIDTH = mlxd_pkg::CountWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  output mlxd_pkg::result_t result_o
);

  mlxd_pkg::phase_e phase_q, phase_d;
  logic [7:0] remain_q, remain_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] size_q, size_d;
  logic [7:0] pos_q, pos_d;
  logic [COUNT_WIDTH-1:0] good_q, good_d;
  logic [COUNT_WIDTH-1:0] bad_q, bad_d;

  always_comb begin
    phase_d  = phase_q;
    remain_d = remain_q;
    xor_d    = xor_q;
    size_d   = size_q;
    pos_d    = pos_q;
    good_d   = good_q;
    bad_d    = bad_q;

    result_o.payload_valid        = 1'b0;
    result_o.payload_byte         = 8'd0;
    result_o.payload_index        = 8'd0;
    result_o.frame_good           = 1'b0;
    result_o.frame_error          = 1'b0;
    result_o.error_kind           = mlxd_pkg::ERR_NONE;
    result_o.frame_payload_length = 8'd0;

    unique case (phase_q)
      mlxd_pkg::PH_LEN: begin
        if (data_byte_i < mlxd_pkg::Overhead) begin
          result_o.frame_error = 1'b1;
          result_o.error_kind  = mlxd_pkg::ERR_SHORT;
          bad_d                = bad_q + COUNT_WIDTH'(1);
          phase_d              = mlxd_pkg::PH_HUNT;
        end else begin
          size_d   = data_byte_i - mlxd_pkg::Overhead;
          remain_d = data_byte_i - mlxd_pkg::Overhead;
          // A frame of overhead only goes straight to the checksum byte.
          phase_d  = (data_byte_i == mlxd_pkg::Overhead) ? mlxd_pkg::PH_CHECK
                                                         : mlxd_pkg::PH_PAYLOAD;
        end
      end
      mlxd_pkg::PH_PAYLOAD: begin
        xor_d                  = xor_q ^ data_byte_i;
        result_o.payload_valid = 1'b1;
        result_o.payload_byte  = data_byte_i;
        result_o.payload_index = pos_q;
        pos_d                  = pos_q + 8'd1;
        remain_d               = remain_q - 8'd1;
        if (remain_q == 8'd1) begin
          phase_d = mlxd_pkg::PH_CHECK;
        end
      end
      mlxd_pkg::PH_CHECK: begin
        if (data_byte_i == xor_q) begin
          phase_d = mlxd_pkg::PH_END;
        end else begin
          result_o.frame_error = 1'b1;
          result_o.error_kind  = mlxd_pkg::ERR_CHECKSUM;
          bad_d                = bad_q + COUNT_WIDTH'(1);
          phase_d              = mlxd_pkg::PH_HUNT;
        end
      end
      mlxd_pkg::PH_END: begin
        if (data_byte_i == mlxd_pkg::EndByte) begin
          result_o.frame_good           = 1'b1;
          result_o.frame_payload_length = size_q;
          good_d                        = good_q + COUNT_WIDTH'(1);
        end else begin
          result_o.frame_error = 1'b1;
          result_o.error_kind  = mlxd_pkg::ERR_END;
          bad_d                = bad_q + COUNT_WIDTH'(1);
        end
        phase_d = mlxd_pkg::PH_HUNT;
      end
      default: begin
        xor_d   = 8'd0;
        pos_d   = 8'd0;
        phase_d = (data_byte_i == mlxd_pkg::StartByte) ? mlxd_pkg::PH_LEN
                                                       : mlxd_pkg::PH_HUNT;
      end
    endcase

    result_o.good_frame_count = 16'(good_d);
    result_o.bad_frame_count  = 16'(bad_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mlxd_pkg::PH_HUNT;
      remain_q <= 8'd0;
      xor_q    <= 8'd0;
      size_q   <= 8'd0;
      pos_q    <= 8'd0;
      good_q   <= '0;
      bad_q    <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      xor_q    <= xor_d;
      size_q   <= size_d;
      pos_q    <= pos_d;
      good_q   <= good_d;
      bad_q    <= bad_d;
    end
  end

endmodule
